FILE: src/b64c_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package b64c_pkg;

  localparam int unsigned DataW   = 8;
  localparam int unsigned CountW  = 7;
  localparam int unsigned StatusW = 3;
  localparam int unsigned QDepth  = 4;
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned QCntW   = $clog2(QDepth + 1);

  localparam logic [CountW-1:0] MAX_DECODE_BYTES = 7'd95;

  typedef enum logic [StatusW-1:0] {
    ST_OK          = 3'd0,
    ST_BAD_CHAR    = 3'd1,
    ST_TOO_MANY    = 3'd2,
    ST_WRONG_COUNT = 3'd3,
    ST_TRAILING    = 3'd4
  } status_t;

  typedef enum logic {
    DIR_ENCODE = 1'b0,
    DIR_DECODE = 1'b1
  } dir_t;

  typedef enum logic {
    CFG_DIRECTION      = 1'b0,
    CFG_EXPECTED_BYTES = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [DataW-1:0]   result_data;
    logic               result_valid;
    logic               result_last;
    logic [StatusW-1:0] status;
  } result_t;

  function automatic result_t mk_result(logic [DataW-1:0] d, logic v, logic l,
                                        status_t s);
    result_t r;
    r.result_data  = d;
    r.result_valid = v;
    r.result_last  = l;
    r.status       = s;
    return r;
  endfunction

  // 6-bit index to alphabet character
  function automatic logic [7:0] char_of(logic [5:0] v);
    logic [7:0] v8;
    v8 = {2'b00, v};
    if (v < 6'd26) begin
      return v8 + 8'd65;
    end else if (v < 6'd52) begin
      return v8 + 8'd71;
    end else if (v < 6'd62) begin
      return v8 - 8'd4;
    end else if (v == 6'd62) begin
      return 8'd45;
    end else begin
      return 8'd95;
    end
  endfunction

  // alphabet character to 0..63, 64 for anything else
  function automatic logic [6:0] value_of(logic [7:0] c);
    logic [7:0] t;
    t = 8'd64;
    if (c >= 8'd65 && c <= 8'd90) begin
      t = c - 8'd65;
    end else if (c >= 8'd97 && c <= 8'd122) begin
      t = c - 8'd71;
    end else if (c >= 8'd48 && c <= 8'd57) begin
      t = c + 8'd4;
    end else if (c == 8'd45) begin
      t = 8'd62;
    end else if (c == 8'd95) begin
      t = 8'd63;
    end
    return t[6:0];
  endfunction

endpackage

`default_nettype wire

FILE: src/b64c_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface b64c_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  logic       has_data;
  logic       last;

  modport source (output valid, output data, output has_data, output last, input ready);
  modport sink   (input valid, input data, input has_data, input last, output ready);
endinterface

interface b64c_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] result_data;
  logic       result_valid;
  logic       result_last;
  logic [2:0] status;

  modport source (output valid, output result_data, output result_valid,
                  output result_last, output status, input ready);
  modport sink   (input valid, input result_data, input result_valid,
                  input result_last, input status, output ready);
endinterface

interface b64c_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [6:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

FILE: src/base64url_stream_codec_unit.sv
// Results of an accepted item are registered into the result queue and appear on out_ch in order.
// Throughput: one item per cycle while each item yields at most one result and out_ch is
// ready; two-result items fill the four-entry result queue, which drains one per cycle.
// in_ch.ready is high while at least two queue entries are free.
// Reset (rst_n low, synchronous) clears the codec state, the registers and the queue.
`timescale 1ns / 1ps
`default_nettype none

module base64url_stream_codec_unit (
  input  wire         clk,
  input  wire         rst_n,
  b64c_in_if.sink     in_ch,
  b64c_out_if.source  out_ch,
  b64c_cfg_if.sink    cfg_ch
);

  // configuration
  b64c_pkg::dir_t                     dir_r;
  logic [b64c_pkg::CountW-1:0]        exp_r;

  // codec state
  logic [1:0]                         ph_r, ph_nxt;
  logic [5:0]                         res_r, res_nxt;
  logic [2:0]                         rb_r, rb_nxt;
  logic [b64c_pkg::CountW-1:0]        bc_r, bc_nxt;
  logic                               failed_r, failed_nxt;

  // result queue
  b64c_pkg::result_t                  q_r [b64c_pkg::QDepth];
  logic [b64c_pkg::QPtrW-1:0]         head_r, tail_r;
  logic [b64c_pkg::QCntW-1:0]         count_r, count_nxt;

  logic                               in_fire, out_fire;
  b64c_pkg::result_t                  r0, r1;
  logic [1:0]                         n_res;
  b64c_pkg::status_t                  err;
  logic [6:0]                         v;
  logic [11:0]                        acc;
  logic [3:0]                         bits4;
  logic [2:0]                         b;
  logic [11:0]                        shifted;
  logic [6:0]                         m7;
  logic [7:0]                         tail_ch;
  logic                               tail_en;

  assign in_ch.ready  = (count_r <= b64c_pkg::QCntW'(2));
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = (count_r != '0);
  assign out_fire     = out_ch.valid && out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.result_data  = q_r[head_r].result_data;
  assign out_ch.result_valid = q_r[head_r].result_valid;
  assign out_ch.result_last  = q_r[head_r].result_last;
  assign out_ch.status       = q_r[head_r].status;

  always_comb begin
    ph_nxt     = ph_r;
    res_nxt    = res_r;
    rb_nxt     = rb_r;
    bc_nxt     = bc_r;
    failed_nxt = failed_r;
    r0         = '0;
    r1         = '0;
    n_res      = 2'd0;
    err        = b64c_pkg::ST_OK;
    v          = '0;
    acc        = '0;
    bits4      = '0;
    b          = '0;
    shifted    = '0;
    m7         = '0;
    tail_ch    = '0;
    tail_en    = 1'b0;

    if (in_fire) begin
      if (failed_r) begin
        // drop everything up to the end of the message
        if (in_ch.last) begin
          ph_nxt     = '0;
          res_nxt    = '0;
          rb_nxt     = '0;
          bc_nxt     = '0;
          failed_nxt = 1'b0;
        end
      end else if (dir_r == b64c_pkg::DIR_ENCODE) begin
        if (in_ch.has_data) begin
          case (ph_r)
            2'd1: begin
              r0 = b64c_pkg::mk_result(
                  b64c_pkg::char_of({res_r[1:0], in_ch.data[7:4]}), 1'b1, 1'b0,
                  b64c_pkg::ST_OK);
              n_res   = 2'd1;
              res_nxt = {2'b00, in_ch.data[3:0]};
              rb_nxt  = 3'd4;
              ph_nxt  = 2'd2;
            end
            2'd2: begin
              r0 = b64c_pkg::mk_result(
                  b64c_pkg::char_of({res_r[3:0], in_ch.data[7:6]}), 1'b1, 1'b0,
                  b64c_pkg::ST_OK);
              r1 = b64c_pkg::mk_result(b64c_pkg::char_of(in_ch.data[5:0]), 1'b1, 1'b0,
                  b64c_pkg::ST_OK);
              n_res   = 2'd2;
              res_nxt = '0;
              rb_nxt  = '0;
              ph_nxt  = 2'd0;
            end
            default: begin
              r0 = b64c_pkg::mk_result(b64c_pkg::char_of(in_ch.data[7:2]), 1'b1, 1'b0,
                  b64c_pkg::ST_OK);
              n_res   = 2'd1;
              res_nxt = {4'b0000, in_ch.data[1:0]};
              rb_nxt  = 3'd2;
              ph_nxt  = 2'd1;
            end
          endcase
        end
        if (in_ch.last) begin
          // short group: emit its tail character
          if (ph_nxt == 2'd1) begin
            tail_en = 1'b1;
            tail_ch = b64c_pkg::char_of({res_nxt[1:0], 4'b0000});
          end else if (ph_nxt == 2'd2) begin
            tail_en = 1'b1;
            tail_ch = b64c_pkg::char_of({res_nxt[3:0], 2'b00});
          end
          if (tail_en) begin
            if (n_res == 2'd0) begin
              r0    = b64c_pkg::mk_result(tail_ch, 1'b1, 1'b0, b64c_pkg::ST_OK);
              n_res = 2'd1;
            end else begin
              r1    = b64c_pkg::mk_result(tail_ch, 1'b1, 1'b0, b64c_pkg::ST_OK);
              n_res = 2'd2;
            end
          end
          if (n_res == 2'd0) begin
            r0    = b64c_pkg::mk_result('0, 1'b0, 1'b1, b64c_pkg::ST_OK);
            n_res = 2'd1;
          end else if (n_res == 2'd1) begin
            r0.result_last = 1'b1;
          end else begin
            r1.result_last = 1'b1;
          end
          ph_nxt  = '0;
          res_nxt = '0;
          rb_nxt  = '0;
          bc_nxt  = '0;
        end
      end else begin
        if (in_ch.has_data) begin
          v = b64c_pkg::value_of(in_ch.data);
          if (v[6]) begin
            err = b64c_pkg::ST_BAD_CHAR;
          end else begin
            acc   = {res_r, v[5:0]};
            bits4 = {1'b0, rb_r} + 4'd6;
            if (bits4 >= 4'd8) begin
              b = 3'(bits4 - 4'd8);
              if (bc_r >= exp_r || bc_r >= b64c_pkg::MAX_DECODE_BYTES) begin
                err = b64c_pkg::ST_TOO_MANY;
              end else begin
                shifted = acc >> b;
                m7      = (7'd1 << b) - 7'd1;
                r0      = b64c_pkg::mk_result(shifted[7:0], 1'b1, 1'b0, b64c_pkg::ST_OK);
                n_res   = 2'd1;
                bc_nxt  = bc_r + 7'd1;
                res_nxt = acc[5:0] & m7[5:0];
                rb_nxt  = b;
              end
            end else begin
              res_nxt = acc[5:0];
              rb_nxt  = bits4[2:0];
            end
            ph_nxt = ph_r + 2'd1;
          end
        end

        if (err == b64c_pkg::ST_OK && in_ch.last) begin
          if (ph_nxt == 2'd1) begin
            err = b64c_pkg::ST_WRONG_COUNT;
          end else if (bc_nxt != exp_r) begin
            err = b64c_pkg::ST_WRONG_COUNT;
          end else if (rb_nxt != '0 && res_nxt != '0) begin
            err = b64c_pkg::ST_TRAILING;
          end
        end

        if (err != b64c_pkg::ST_OK) begin
          if (n_res == 2'd0) begin
            r0    = b64c_pkg::mk_result('0, 1'b0, 1'b1, err);
            n_res = 2'd1;
          end else begin
            r1    = b64c_pkg::mk_result('0, 1'b0, 1'b1, err);
            n_res = 2'd2;
          end
          ph_nxt     = '0;
          res_nxt    = '0;
          rb_nxt     = '0;
          bc_nxt     = '0;
          failed_nxt = !in_ch.last;
        end else if (in_ch.last) begin
          if (n_res == 2'd0) begin
            r0    = b64c_pkg::mk_result('0, 1'b0, 1'b1, b64c_pkg::ST_OK);
            n_res = 2'd1;
          end else begin
            r0.result_last = 1'b1;
          end
          ph_nxt  = '0;
          res_nxt = '0;
          rb_nxt  = '0;
          bc_nxt  = '0;
        end
      end
    end

    count_nxt = count_r + b64c_pkg::QCntW'(n_res) - b64c_pkg::QCntW'(out_fire);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r    <= b64c_pkg::DIR_ENCODE;
      exp_r    <= '0;
      ph_r     <= '0;
      res_r    <= '0;
      rb_r     <= '0;
      bc_r     <= '0;
      failed_r <= 1'b0;
      head_r   <= '0;
      tail_r   <= '0;
      count_r  <= '0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        unique case (b64c_pkg::cfg_idx_t'(cfg_ch.index))
          b64c_pkg::CFG_DIRECTION:      dir_r <= b64c_pkg::dir_t'(cfg_ch.wdata[0]);
          b64c_pkg::CFG_EXPECTED_BYTES: exp_r <= cfg_ch.wdata;
        endcase
      end
      ph_r     <= ph_nxt;
      res_r    <= res_nxt;
      rb_r     <= rb_nxt;
      bc_r     <= bc_nxt;
      failed_r <= failed_nxt;
      tail_r   <= tail_r + b64c_pkg::QPtrW'(n_res);
      if (out_fire) begin
        head_r <= head_r + 1'b1;
      end
      count_r  <= count_nxt;
    end
  end

  // queue payload: no reset
  always_ff @(posedge clk) begin
    if (n_res != 2'd0) begin
      q_r[tail_r] <= r0;
    end
    if (n_res == 2'd2) begin
      q_r[tail_r + 1'b1] <= r1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= b64c_pkg::QCntW'(b64c_pkg::QDepth))
    else $error("result queue overfilled");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.last) |=> !failed_r)
    else $error("discard state survives the end of a message");

  a_discard_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && failed_r) |=> (count_r <= $past(count_r)))
    else $error("result queued while discarding");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.result_valid) |-> (out_ch.result_data == '0))
    else $error("marker or error transaction carries data");

  a_error_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != b64c_pkg::ST_OK) |->
      (out_ch.result_last && !out_ch.result_valid))
    else $error("error transaction not marked final");

endmodule

`default_nettype wire
